>>> src/shash_pkg.sv
package shash_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int WORD_BYTES      = 4;
    localparam int BLOCK_BYTES     = 64;
    localparam int LEN_POS         = 56;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } dig_word_t;

    typedef struct packed {
        logic start;
        logic init;
    } cmp_ctrl_t;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_PAD,
        ST_ZERO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_FIN,
        ST_OUT
    } back_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'h428A2F98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;
            6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;
            6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;
            6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;
            6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;
            6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;
            6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;
            6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;
            6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;
            6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;
            6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;
            6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;
            6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;
            6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;
            6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;
            6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;
            6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;
            6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;
            6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;
            6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;
            6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;
            6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;
            6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;
            6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;
            6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;
            6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;
            6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;
            6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;
            6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;
            6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;
            6'd63: k = 32'hC67178F2;
        endcase
        return k;
    endfunction

endpackage

>>> src/shash_front.sv
module shash_front
    import shash_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    output logic      msg_stall,
    input  msg_word_t msg,
    output logic      q_valid,
    output msg_word_t q_word,
    input  logic      q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    msg_word_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    msg_word_t        clean;

    assign msg_stall = (count_reg == FULL_CNT);
    assign push      = msg_valid && !msg_stall;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (count_reg != '0);
    assign q_word    = slot_reg[rd_ptr_reg];

    // over-long byte counts act as a full word
    always_comb
    begin
        clean = msg;
        if (msg.byte_count > 3'(WORD_BYTES))
        begin
            clean.byte_count = 3'(WORD_BYTES);
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= clean;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

>>> src/shash_compress.sv
module shash_compress
    import shash_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmp_ctrl_t    ctrl,
    input  logic [511:0] block,
    output logic         busy,
    output logic [255:0] chain
);

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [6:0]  rnd_reg, rnd_next;
    logic        busy_reg, busy_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign t1 = v_reg[7]
              + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(rnd_reg[5:0]) + w_reg[0];
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
                 + w_reg[9]
                 + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
                 + w_reg[0];

    assign busy = busy_reg;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            chain[255 - 32 * j -: 32] = chain_reg[j];
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        rnd_next   = rnd_reg;
        busy_next  = busy_reg;
        if (ctrl.init)
        begin
            chain_next = INIT_H;
        end
        if (ctrl.start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_next[i] = block[511 - 32 * i -: 32];
            end
            v_next    = chain_reg;
            rnd_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rnd_reg[6])
            begin
                for (int j = 0; j < 8; j++)
                begin
                    chain_next[j] = chain_reg[j] + v_reg[j];
                end
                busy_next = 1'b0;
            end
            else
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = w_new;
                rnd_next   = rnd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_H;
            rnd_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            rnd_reg   <= rnd_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("block started while compressing");
`endif

endmodule

>>> src/shash_back.sv
module shash_back
    import shash_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  msg_word_t    q_word,
    output logic         q_pop,
    output cmp_ctrl_t    cmp,
    output logic [511:0] block,
    input  logic         busy,
    input  logic [255:0] chain,
    output logic         dig_valid,
    input  logic         dig_stall,
    output dig_word_t    dig
);

    back_state_t  state_reg, state_next;
    logic [6:0]   fill_reg, fill_next;
    logic [1:0]   off_reg, off_next;
    logic [63:0]  bitlen_reg, bitlen_next;
    logic [2:0]   idx_reg, idx_next;
    logic         dig_valid_reg, dig_valid_next;
    dig_word_t    dig_reg, dig_next;
    logic [511:0] buf_reg, buf_next;
    logic [31:0]  src;
    logic [2:0]   n;
    logic [2:0]   k;
    logic [6:0]   room;
    logic [6:0]   gap;
    logic         flush;
    logic         emit;

    assign room  = 7'(BLOCK_BYTES) - fill_reg;
    assign k     = ({4'b0, n} < room) ? n : room[2:0];
    assign flush = (fill_reg == 7'(BLOCK_BYTES)) && !busy;
    assign emit  = (state_reg == ST_OUT) && (!dig_valid_reg || !dig_stall);
    assign gap   = ((fill_reg <= 7'(LEN_POS)) ? 7'(LEN_POS) : 7'(BLOCK_BYTES)) - fill_reg;

    assign block     = buf_reg;
    assign dig_valid = dig_valid_reg;
    assign dig       = dig_reg;

    // byte source for this cycle
    always_comb
    begin
        src = '0;
        n   = '0;
        unique case (state_reg)
            ST_DATA:
            begin
                if (q_valid)
                begin
                    src = q_word.data_word << {off_reg, 3'b000};
                    n   = q_word.byte_count - {1'b0, off_reg};
                end
            end
            ST_PAD:
            begin
                src = PAD_WORD;
                n   = 3'd1;
            end
            ST_ZERO:
            begin
                n = (gap > 7'(WORD_BYTES)) ? 3'(WORD_BYTES) : gap[2:0];
            end
            ST_LEN_HI:
            begin
                src = bitlen_reg[63:32];
                n   = 3'(WORD_BYTES);
            end
            ST_LEN_LO:
            begin
                src = bitlen_reg[31:0];
                n   = 3'(WORD_BYTES);
            end
            ST_FIN, ST_OUT:
            begin
                n = '0;
            end
            default:
            begin
                n = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        bitlen_next    = bitlen_reg;
        idx_next       = idx_reg;
        dig_valid_next = dig_valid_reg;
        dig_next       = dig_reg;
        q_pop          = 1'b0;
        cmp.start      = flush;
        cmp.init       = 1'b0;
        fill_next      = (flush ? 7'd0 : fill_reg) + {4'b0, k};

        case (k)
            3'd1:    buf_next = {buf_reg[503:0], src[31:24]};
            3'd2:    buf_next = {buf_reg[495:0], src[31:16]};
            3'd3:    buf_next = {buf_reg[487:0], src[31:8]};
            3'd4:    buf_next = {buf_reg[479:0], src};
            default: buf_next = buf_reg;
        endcase

        if (dig_valid_reg && !dig_stall)
        begin
            dig_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_DATA:
            begin
                bitlen_next = bitlen_reg + {58'b0, k, 3'b000};
                if (q_valid)
                begin
                    if (k == n)
                    begin
                        q_pop    = 1'b1;
                        off_next = '0;
                        if (q_word.last)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else
                    begin
                        off_next = off_reg + k[1:0];
                    end
                end
            end
            ST_PAD:
            begin
                if (k == n)
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (fill_reg == 7'(LEN_POS))
                begin
                    state_next = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (k == n)
                begin
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (k == n)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fill_reg == '0 && !busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (emit)
                begin
                    dig_valid_next       = 1'b1;
                    dig_next.digest_word = chain[255 - 32 * idx_reg -: 32];
                    dig_next.word_index  = idx_reg;
                    dig_next.digest_last = (idx_reg == 3'd7);
                    idx_next             = idx_reg + 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        cmp.init    = 1'b1;
                        bitlen_next = '0;
                        state_next  = ST_DATA;
                    end
                end
            end
            default:
            begin
                state_next = ST_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DATA;
            fill_reg      <= '0;
            off_reg       <= '0;
            bitlen_reg    <= '0;
            idx_reg       <= '0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            off_reg       <= off_next;
            bitlen_reg    <= bitlen_next;
            idx_reg       <= idx_next;
            dig_valid_reg <= dig_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        dig_reg <= dig_next;
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 7'(BLOCK_BYTES))
        else $error("block fill out of range");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (!busy && fill_reg == '0))
        else $error("digest read while a block is pending");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && idx_reg == 3'd7) |=> (state_reg == ST_DATA && bitlen_reg == '0))
        else $error("no restart after final digest word");
`endif

endmodule

>>> src/sha256_stream_hasher.sv
// channel | valid     | stall     | payload                                  | dir
// msg     | msg_valid | msg_stall | msg : data_word, byte_count, last        | in
// dig     | dig_valid | dig_stall | dig : digest_word, word_index, digest_last | out
//
// while the round unit compresses a full 16-word block, words pack into the next block
// meanwhile, and that block starts once the round unit is idle
// a last word adds padding and the 64-bit length, then the final block is compressed
// (a second block when the length spills over), then eight digest words go out
// at one per cycle while dig_stall is low
// rst_n clears all control state and loads the initial hash values
// an input queue keeps taking words, until it is full, while the digest register waits on dig_stall
module sha256_stream_hasher
    import shash_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    output logic      msg_stall,
    input  msg_word_t msg,
    output logic      dig_valid,
    input  logic      dig_stall,
    output dig_word_t dig
);

    logic         q_valid;
    msg_word_t    q_word;
    logic         q_pop;
    cmp_ctrl_t    cmp;
    logic [511:0] block;
    logic         busy;
    logic [255:0] chain;

    shash_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop)
    );

    shash_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .cmp       (cmp),
        .block     (block),
        .busy      (busy),
        .chain     (chain),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    shash_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cmp),
        .block (block),
        .busy  (busy),
        .chain (chain)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import shash_pkg::*;

    localparam int unsigned HANG_LIMIT   = 300000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned RUN_WORDS    = 210;

    class digest_scoreboard;
        localparam bit [7:0] PAD_BYTE = 8'h80;
        localparam int unsigned LENGTH_AT = 56;

        localparam bit [31:0] IV [8] = '{
            32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
            32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
        };

        localparam bit [31:0] K [64] = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
        };

        bit [31:0]   hash_state [8];
        bit [31:0]   msg_block [16];
        int unsigned fill;
        bit [63:0]   msg_bits;
        dig_word_t   digest_q [$];
        int unsigned errors;
        int unsigned words_seen;
        int unsigned messages;
        int unsigned digests_checked;

        function new();
            hash_state = IV;
            fill = 0;
            msg_bits = '0;
            errors = 0;
            words_seen = 0;
            messages = 0;
            digests_checked = 0;
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void fold_block();
            bit [31:0] w [16];
            bit [31:0] v [8];
            bit [31:0] wt, s0, s1, t1, t2;
            w = msg_block;
            v = hash_state;
            for (int r = 0; r < 64; r++)
            begin
                if (r < 16)
                begin
                    wt = w[r];
                end
                else
                begin
                    s0 = rotr(w[(r + 1) & 15], 7) ^ rotr(w[(r + 1) & 15], 18)
                         ^ (w[(r + 1) & 15] >> 3);
                    s1 = rotr(w[(r + 14) & 15], 17) ^ rotr(w[(r + 14) & 15], 19)
                         ^ (w[(r + 14) & 15] >> 10);
                    wt = s1 + w[(r + 9) & 15] + s0 + w[r & 15];
                    w[r & 15] = wt;
                end
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[r] + wt;
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++)
            begin
                hash_state[j] = hash_state[j] + v[j];
            end
        endfunction

        function void absorb_byte(bit [7:0] b);
            msg_block[fill >> 2][(3 - (fill & 3)) * 8 +: 8] = b;
            fill++;
            if (fill == 64)
            begin
                fold_block();
                fill = 0;
            end
        endfunction

        function void note_word(msg_word_t m);
            int unsigned n;
            bit [63:0] len;
            dig_word_t d;
            n = (m.byte_count > 4) ? 4 : m.byte_count;
            words_seen++;
            for (int i = 0; i < n; i++)
            begin
                absorb_byte(m.data_word[31 - 8 * i -: 8]);
                msg_bits = msg_bits + 64'd8;
            end
            if (!m.last)
            begin
                return;
            end
            len = msg_bits;
            absorb_byte(PAD_BYTE);
            while (fill != LENGTH_AT)
            begin
                absorb_byte(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                absorb_byte(len[63 - 8 * i -: 8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index  = 3'(i);
                d.digest_last = (i == 7);
                digest_q.push_back(d);
            end
            messages++;
            hash_state = IV;
            fill = 0;
            msg_bits = '0;
        endfunction

        function void check_digest(dig_word_t d);
            dig_word_t e;
            digests_checked++;
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h index %0d", d.digest_word, d.word_index);
                errors++;
                return;
            end
            e = digest_q.pop_front();
            if (d.digest_word !== e.digest_word)
            begin
                $error("digest_word: expected %h, got %h", e.digest_word, d.digest_word);
                errors++;
            end
            if (d.word_index !== e.word_index)
            begin
                $error("word_index: expected %0d, got %0d", e.word_index, d.word_index);
                errors++;
            end
            if (d.digest_last !== e.digest_last)
            begin
                $error("digest_last: expected %0b, got %0b", e.digest_last, d.digest_last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction
    endclass

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      msg_valid = 1'b0;
    logic      msg_stall;
    msg_word_t msg = '0;
    logic      dig_valid;
    logic      dig_stall = 1'b0;
    dig_word_t dig;

    digest_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int          burst_left = 8;
    int unsigned stall_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    sha256_stream_hasher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > HANG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && msg_valid && !msg_stall)
        begin
            sb.note_word(msg);
        end
        if (rst_n && dig_valid && !dig_stall)
        begin
            sb.check_digest(dig);
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 120);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     dig_stall <= 1'b0;
            STALL_LIGHT:    dig_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    dig_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: dig_stall <= (cycles[2:0] < 3);
            default:        dig_stall <= 1'b0;
        endcase
    end

    task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                             input logic fin);
        msg_word_t w;
        w.data_word  = data;
        w.byte_count = cnt;
        w.last       = fin;
        msg <= w;
        msg_valid <= 1'b1;
        @(posedge clk);
        while (msg_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic drain();
        msg_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_message(input int unsigned nwords);
        logic [2:0] cnt;
        logic       fin;
        for (int unsigned k = 0; k < nwords; k++)
        begin
            fin = (k == nwords - 1);
            if (fin || $urandom_range(0, 9) == 0)
            begin
                cnt = 3'($urandom_range(0, 7));
            end
            else
            begin
                cnt = 3'd4;
            end
            send_word($urandom, cnt, fin);
        end
    endtask

    initial
    begin
        int unsigned pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, "abc", oversized count on a last word
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h6162_6300, 3'd3, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);

        // short words in mid-message
        send_word(32'h0000_0000, 3'd4, 1'b0);
        send_word(32'h1234_5678, 3'd2, 1'b0);
        send_word(32'h9ABC_DEF0, 3'd1, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd5, 1'b0);
        send_word(32'hAAAA_AAAA, 3'd6, 1'b1);

        // 56 bytes: length spills into a second block
        for (int k = 0; k < 14; k++)
        begin
            send_word($urandom, 3'd4, (k == 13));
        end
        drain();

        while (items_sent < RUN_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                send_message($urandom_range(1, 16));
            end
            else if (pick < 9)
            begin
                send_message($urandom_range(13, 18));
            end
            else
            begin
                send_message($urandom_range(17, 40));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
            end
        end
        drain();

        $display("covered %0d messages in %0d words, byte counts 0 to 7, one- and two-block padding",
                 sb.messages, sb.words_seen);
        $display("checked %0d digest words under varied sender gaps and receiver stalls",
                 sb.digests_checked);
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
src/shash_pkg.sv
src/shash_front.sv
src/shash_compress.sv
src/shash_back.sv
src/sha256_stream_hasher.sv
sim/testbench.sv
